FILE: rtl/core/isa_pkg.sv
// Shared types, constants and helpers of the interval set algebra unit.
package isa_pkg;

	localparam int MaxIntervals = 16;
	localparam int CntW = $clog2(MaxIntervals + 1);
	localparam int IdxW = (MaxIntervals > 1) ? $clog2(MaxIntervals) : 1;
	localparam int EvtCap = 4 * MaxIntervals;
	localparam int EvtCntW = $clog2(EvtCap + 1);
	localparam int MaxResults = 32;
	localparam int ResCntW = $clog2(MaxResults + 1);
	localparam int SweepW = $clog2(MaxIntervals + 2) + 1;

	localparam logic [2:0] FUNC_LOAD_A = 3'd0;
	localparam logic [2:0] FUNC_LOAD_B = 3'd1;
	localparam logic [2:0] FUNC_ISECT  = 3'd2;
	localparam logic [2:0] FUNC_UNITE  = 3'd3;
	localparam logic [2:0] FUNC_CLEAR  = 3'd4;
	localparam logic [2:0] FUNC_QUERY  = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_DUP  = 2'd2;

	localparam logic [1:0] OP_AND  = 2'd0;
	localparam logic [1:0] OP_OR   = 2'd1;
	localparam logic [1:0] OP_DIFF = 2'd2;

	localparam logic CFG_COMP_A = 1'b0;
	localparam logic CFG_COMP_B = 1'b1;

	// One endpoint event. Sort key is {pos, kind, side}, with pos biased
	// to unsigned order.
	typedef struct packed {
		logic        valid;
		logic signed [31:0] pos;
		logic        kind;   // 0 open, 1 close
		logic        side;   // 0 left operand, 1 right operand
	} evt_t;

	function automatic logic evt_before(evt_t x, evt_t y);
		logic [33:0] kx;
		logic [33:0] ky;
		kx = {~x.pos[31], x.pos[30:0], x.kind, x.side};
		ky = {~y.pos[31], y.pos[30:0], y.kind, y.side};
		// Empty slots sort after all real events.
		return x.valid && (!y.valid || (kx < ky));
	endfunction

endpackage

FILE: rtl/core/isa_sort_cell.sv
// One cell of the insertion sorter: keeps the smaller event, passes the larger on.
module isa_sort_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         flush,
	input  logic         shift,
	input  isa_pkg::evt_t in_evt,
	input  isa_pkg::evt_t left_evt,
	output isa_pkg::evt_t held,
	output isa_pkg::evt_t pass_evt
);
	isa_pkg::evt_t held_q;
	isa_pkg::evt_t pass_q;

	assign held     = held_q;
	assign pass_evt = pass_q;

	// In sort mode the cell keeps the smaller of its entry and the
	// incoming event. In shift mode the row moves towards cell zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q.valid <= 1'b0;
			pass_q.valid <= 1'b0;
		end else if (flush) begin
			held_q.valid <= 1'b0;
			pass_q.valid <= 1'b0;
		end else if (shift) begin
			held_q <= left_evt;
			pass_q.valid <= 1'b0;
		end else if (isa_pkg::evt_before(in_evt, held_q)) begin
			pass_q <= held_q;
			held_q <= in_evt;
		end else begin
			pass_q <= in_evt;
		end
	end
endmodule

FILE: rtl/core/isa_store.sv
// Interval store with duplicate search, fill count and point query.
module isa_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clear,
	input  logic                      wr,
	input  logic signed [31:0]        wr_lo,
	input  logic signed [31:0]        wr_hi,
	input  logic [isa_pkg::IdxW-1:0]  rd_idx,
	output logic signed [31:0]        rd_lo,
	output logic signed [31:0]        rd_hi,
	output logic                      dup,
	output logic                      hit,
	output logic [isa_pkg::CntW-1:0]  count
);
	logic signed [31:0] lo_q [isa_pkg::MaxIntervals];
	logic signed [31:0] hi_q [isa_pkg::MaxIntervals];
	logic [isa_pkg::CntW-1:0] count_q;
	logic [isa_pkg::MaxIntervals-1:0] dup_v;
	logic [isa_pkg::MaxIntervals-1:0] hit_v;

	assign count = count_q;
	assign rd_lo = lo_q[rd_idx];
	assign rd_hi = hi_q[rd_idx];

	// Each entry compares independently; the result is an OR reduce.
	always_comb begin
		for (int i = 0; i < isa_pkg::MaxIntervals; i++) begin
			dup_v[i] = (isa_pkg::CntW'(i) < count_q) && (lo_q[i] == wr_lo) &&
				(hi_q[i] == wr_hi);
			hit_v[i] = (isa_pkg::CntW'(i) < count_q) && (lo_q[i] <= wr_lo) &&
				(wr_lo <= hi_q[i]);
		end
	end
	assign dup = |dup_v;
	assign hit = |hit_v;

	always_ff @(posedge clk) begin
		if (wr) begin
			lo_q[count_q[isa_pkg::IdxW-1:0]] <= wr_lo;
			hi_q[count_q[isa_pkg::IdxW-1:0]] <= wr_hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (wr) begin
			count_q <= count_q + 1'b1;
		end
	end
endmodule

FILE: rtl/core/interval_set_algebra_unit.sv
// Top level of the interval set algebra unit: control, sorter row and sweep.
//
//  channel   | direction | payload
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | tdata: func[2:0], lo[34:3], hi[66:35], zero pad
//  m_axis    | out       | tdata: res_lo, res_hi, res_complement,
//            |           |        result_empty, is_member, status; tlast: last
//  cfg       | in        | cfg_we, cfg_index (0 complement_a, 1 complement_b)
//
// Loads, clear and query are decided at the accepting edge; the result is
// offered from the next cycle. A compute item feeds its endpoint events into
// a row of 4*MaxIntervals sort cells, one event per cycle, left operand
// first, lets the row settle in the drain state, then shifts the sorted row
// out through the sweep, one event per cycle while the output is free, with
// a pass through the done state after each result interval.
// Reset clears the store counts, the flags and all control; store contents
// stay undefined. A stalled output holds the sweep until the result is taken.
module interval_set_algebra_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // func, lo, hi from bit 0, zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // res_lo, res_hi, res_complement,
	                                    // result_empty, is_member, status
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data
);
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_FEED  = 5'b00010,
		S_DRAIN = 5'b00100,
		S_SWEEP = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	localparam int NCell = isa_pkg::EvtCap;

	state_t state_q;
	logic comp_a_q, comp_b_q;
	logic [2:0] func;
	logic signed [31:0] in_lo, in_hi;

	logic out_v_q, out_last_q, out_comp_q, out_empty_q, out_mem_q;
	logic signed [31:0] out_lo_q, out_hi_q;
	logic [1:0] out_st_q;
	logic out_free;
	logic out_send;
	logic [1:0] load_st;

	logic [1:0] op_q;
	logic a_left_q, comp_q;
	logic feed_side_q;       // 0 first operand, 1 second
	logic feed_close_q;      // emit close next
	logic [isa_pkg::CntW-1:0] feed_idx_q;
	logic [isa_pkg::EvtCntW-1:0] cnt_q;
	logic on_q;
	logic signed [31:0] start_q;
	logic signed [31:0] pend_lo_q, pend_hi_q;
	logic signed [isa_pkg::SweepW-1:0] cl_q, cr_q;
	logic [isa_pkg::ResCntW-1:0] k_q;

	isa_pkg::evt_t feed_evt;
	isa_pkg::evt_t held [NCell];
	isa_pkg::evt_t pass [NCell];
	logic flush, shift;

	logic wr_a, wr_b, clr;
	logic signed [31:0] ra_lo, ra_hi, rb_lo, rb_hi;
	logic dup_a, dup_b, hit_a, hit_b;
	logic [isa_pkg::CntW-1:0] cnt_a, cnt_b;
	logic [isa_pkg::IdxW-1:0] rd_idx;
	logic in_fire;

	assign func  = s_axis_tdata[2:0];
	assign in_lo = s_axis_tdata[34:3];
	assign in_hi = s_axis_tdata[66:35];
	assign out_free = !out_v_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {3'b0, out_st_q, out_mem_q, out_empty_q, out_comp_q,
		out_hi_q, out_lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_a_q <= 1'b0;
			comp_b_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				isa_pkg::CFG_COMP_A: comp_a_q <= cfg_data;
				isa_pkg::CFG_COMP_B: comp_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stores: both read at the feeder's index.
	assign rd_idx = feed_idx_q[isa_pkg::IdxW-1:0];
	assign clr  = in_fire && (func == isa_pkg::FUNC_CLEAR);
	assign wr_a = in_fire && (func == isa_pkg::FUNC_LOAD_A) && !dup_a &&
		(cnt_a < isa_pkg::CntW'(isa_pkg::MaxIntervals));
	assign wr_b = in_fire && (func == isa_pkg::FUNC_LOAD_B) && !dup_b &&
		(cnt_b < isa_pkg::CntW'(isa_pkg::MaxIntervals));

	isa_store u_store_a (.clk, .arst_n, .clear(clr), .wr(wr_a), .wr_lo(in_lo),
		.wr_hi(in_hi), .rd_idx, .rd_lo(ra_lo), .rd_hi(ra_hi), .dup(dup_a),
		.hit(hit_a), .count(cnt_a));
	isa_store u_store_b (.clk, .arst_n, .clear(clr), .wr(wr_b), .wr_lo(in_lo),
		.wr_hi(in_hi), .rd_idx, .rd_lo(rb_lo), .rd_hi(rb_hi), .dup(dup_b),
		.hit(hit_b), .count(cnt_b));

	// Load status: a duplicate is found before fullness is looked at.
	always_comb begin
		load_st = isa_pkg::ST_OK;
		if (func == isa_pkg::FUNC_LOAD_A) begin
			load_st = dup_a ? isa_pkg::ST_DUP :
				(wr_a ? isa_pkg::ST_OK : isa_pkg::ST_FULL);
		end else if (func == isa_pkg::FUNC_LOAD_B) begin
			load_st = dup_b ? isa_pkg::ST_DUP :
				(wr_b ? isa_pkg::ST_OK : isa_pkg::ST_FULL);
		end
	end

	// Feeder: the operand order picks which store is the left side.
	logic use_a;
	logic [isa_pkg::CntW-1:0] feed_cnt;
	assign use_a = (feed_side_q == 1'b0) ? a_left_q : !a_left_q;
	assign feed_cnt = use_a ? cnt_a : cnt_b;
	always_comb begin
		feed_evt.valid = (state_q == S_FEED) && (feed_idx_q < feed_cnt);
		feed_evt.kind  = feed_close_q;
		feed_evt.side  = feed_side_q;
		if (use_a) feed_evt.pos = feed_close_q ? ra_hi : ra_lo;
		else       feed_evt.pos = feed_close_q ? rb_hi : rb_lo;
	end

	assign flush = in_fire;
	logic sweep_go;
	assign sweep_go = (state_q == S_SWEEP) && out_free;
	assign shift = sweep_go;

	genvar g;
	generate
		for (g = 0; g < NCell; g++) begin : g_cell
			isa_pkg::evt_t cin, lin;
			if (g == 0) begin : g_first
				assign cin = feed_evt;
			end else begin : g_rest
				assign cin = pass[g-1];
			end
			if (g == NCell - 1) begin : g_end
				assign lin = '0;
			end else begin : g_mid
				assign lin = held[g+1];
			end
			isa_sort_cell u_cell (.clk, .arst_n, .flush, .shift, .in_evt(cin),
				.left_evt(lin), .held(held[g]), .pass_evt(pass[g]));
		end
	endgenerate

	// Sweep over the head cell.
	isa_pkg::evt_t head;
	logic signed [isa_pkg::SweepW-1:0] cl_n, cr_n;
	logic f, emit, fin;
	assign head = held[0];
	always_comb begin
		cl_n = cl_q;
		cr_n = cr_q;
		if (head.side == 1'b0) cl_n = head.kind ? cl_q - 1'b1 : cl_q + 1'b1;
		else                   cr_n = head.kind ? cr_q - 1'b1 : cr_q + 1'b1;
		unique case (op_q)
			isa_pkg::OP_AND: f = (cl_n > 0) && (cr_n > 0);
			isa_pkg::OP_OR:  f = (cl_n > 0) || (cr_n > 0);
			default:         f = (cl_n > 0) && (cr_n <= 0);
		endcase
	end
	assign emit = head.valid && on_q && !f &&
		(k_q < isa_pkg::ResCntW'(isa_pkg::MaxResults));
	assign fin = !head.valid;

	// A result is offered after a single-result item, after each finished
	// interval once the next one is known, and at the end of a sweep.
	assign out_send = (in_fire && ((func == isa_pkg::FUNC_LOAD_A) ||
		(func == isa_pkg::FUNC_LOAD_B) || (func == isa_pkg::FUNC_CLEAR) ||
		(func == isa_pkg::FUNC_QUERY))) ||
		(sweep_go && fin) || (sweep_go && emit && (k_q != '0)) ||
		((state_q == S_DONE) && out_free &&
		(k_q == isa_pkg::ResCntW'(isa_pkg::MaxResults)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_send) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_last_q <= 1'b0;
			feed_side_q <= 1'b0;
			feed_close_q <= 1'b0;
			feed_idx_q <= '0;
			cnt_q <= '0;
			on_q <= 1'b0;
			k_q <= '0;
			cl_q <= '0;
			cr_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						out_lo_q <= '0;
						out_hi_q <= '0;
						out_comp_q <= 1'b0;
						out_empty_q <= 1'b0;
						out_mem_q <= (func == isa_pkg::FUNC_QUERY) && (hit_a ^ comp_a_q);
						out_st_q <= load_st;
						out_last_q <= 1'b1;
						feed_side_q <= 1'b0;
						feed_close_q <= 1'b0;
						feed_idx_q <= '0;
						cnt_q <= '0;
						on_q <= 1'b0;
						k_q <= '0;
						cl_q <= '0;
						cr_q <= '0;
						unique case (func)
							isa_pkg::FUNC_ISECT, isa_pkg::FUNC_UNITE: begin
								state_q <= S_FEED;
								// Table of operation, operand order and
								// result complement per flag pair.
								priority if (!comp_a_q && !comp_b_q) begin
									op_q <= (func == isa_pkg::FUNC_ISECT) ?
										isa_pkg::OP_AND : isa_pkg::OP_OR;
									a_left_q <= 1'b1;
									comp_q <= 1'b0;
								end else if (comp_a_q && comp_b_q) begin
									op_q <= (func == isa_pkg::FUNC_ISECT) ?
										isa_pkg::OP_OR : isa_pkg::OP_AND;
									a_left_q <= 1'b1;
									comp_q <= 1'b1;
								end else if (comp_a_q) begin
									op_q <= isa_pkg::OP_DIFF;
									a_left_q <= (func == isa_pkg::FUNC_UNITE);
									comp_q <= (func == isa_pkg::FUNC_UNITE);
								end else begin
									op_q <= isa_pkg::OP_DIFF;
									a_left_q <= (func == isa_pkg::FUNC_ISECT);
									comp_q <= (func == isa_pkg::FUNC_UNITE);
								end
							end
							default: ;
						endcase
					end
				end
				S_FEED: begin
					// One event per cycle: open then close of each entry.
					if (feed_idx_q < feed_cnt) begin
						feed_close_q <= !feed_close_q;
						if (feed_close_q) feed_idx_q <= feed_idx_q + 1'b1;
					end else if (feed_side_q == 1'b0) begin
						feed_side_q <= 1'b1;
						feed_idx_q <= '0;
						feed_close_q <= 1'b0;
					end else begin
						state_q <= S_DRAIN;
						cnt_q <= '0;
					end
				end
				S_DRAIN: begin
					// Let the last event ripple to the end of the row.
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == isa_pkg::EvtCntW'(NCell)) state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (sweep_go) begin
						if (fin) begin
							state_q <= S_IDLE;
							out_last_q <= 1'b1;
							out_comp_q <= comp_q;
							if (k_q == '0) begin
								out_lo_q <= '0;
								out_hi_q <= '0;
								out_empty_q <= 1'b1;
							end else begin
								// The held-back interval is the final one.
								out_lo_q <= pend_lo_q;
								out_hi_q <= pend_hi_q;
								out_empty_q <= 1'b0;
							end
						end else begin
							cl_q <= cl_n;
							cr_q <= cr_n;
							if (!on_q && f) begin
								on_q <= 1'b1;
								start_q <= head.pos;
							end else if (on_q && !f) begin
								on_q <= 1'b0;
							end
							if (emit) begin
								// Send the previously held interval and
								// hold the new one until the end is known.
								if (k_q != '0) begin
									out_lo_q <= pend_lo_q;
									out_hi_q <= pend_hi_q;
									out_comp_q <= comp_q;
									out_empty_q <= 1'b0;
									out_last_q <= 1'b0;
								end
								state_q <= S_DONE;
								pend_lo_q <= start_q;
								pend_hi_q <= head.pos;
								k_q <= k_q + 1'b1;
							end
						end
					end
				end
				S_DONE: begin
					// After the 32nd interval stop early and mark it last.
					if (k_q == isa_pkg::ResCntW'(isa_pkg::MaxResults)) begin
						if (out_free) begin
							out_lo_q <= pend_lo_q;
							out_hi_q <= pend_hi_q;
							out_comp_q <= comp_q;
							out_empty_q <= 1'b0;
							out_last_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_SWEEP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: sim/interval_set_algebra_unit_test.sv
// Randomized self-checking testbench of the interval set algebra unit.
module interval_set_algebra_unit_test;

	// One expected or observed result transfer.
	typedef struct packed {
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic               comp;
		logic               empty;
		logic               member;
		logic [1:0]         status;
		logic               last;
	} res_item_t;

	typedef struct {
		logic signed [31:0] lo;
		logic signed [31:0] hi;
	} span_t;

	typedef struct {
		logic signed [31:0] pos;
		logic               kind;
		logic               side;
	} sevt_t;

	// Scoreboard: holds its own copy of the stores and flags and predicts results.
	class set_algebra_scoreboard;
		span_t     a_list[$];
		span_t     b_list[$];
		logic      comp_a;
		logic      comp_b;
		res_item_t pending[$];
		int        errors;

		function new();
			comp_a = 0;
			comp_b = 0;
			errors = 0;
		endfunction

		function automatic bit evt_less(sevt_t x, sevt_t y);
			if (x.pos != y.pos) return x.pos < y.pos;
			if (x.kind != y.kind) return x.kind < y.kind;
			return x.side < y.side;
		endfunction

		// Sweep over both stores; left and right operands chosen by a_left.
		function automatic void sweep(logic [1:0] op, bit a_left, logic comp);
			sevt_t     evs[$];
			sevt_t     e;
			span_t     l[$];
			span_t     r[$];
			int        cl, cr, k, j;
			bit        on, f;
			logic signed [31:0] start;
			res_item_t it;
			if (a_left) begin
				l = a_list; r = b_list;
			end else begin
				l = b_list; r = a_list;
			end
			foreach (l[i]) begin
				evs.insert(evs.size(), sevt_t'{l[i].lo, 1'b0, 1'b0});
				evs.insert(evs.size(), sevt_t'{l[i].hi, 1'b1, 1'b0});
			end
			foreach (r[i]) begin
				evs.insert(evs.size(), sevt_t'{r[i].lo, 1'b0, 1'b1});
				evs.insert(evs.size(), sevt_t'{r[i].hi, 1'b1, 1'b1});
			end
			// Stable insertion sort, same tie order as the hardware key.
			for (int i = 1; i < evs.size(); i++) begin
				e = evs[i];
				j = i;
				while (j > 0 && evt_less(e, evs[j-1])) begin
					evs[j] = evs[j-1];
					j--;
				end
				evs[j] = e;
			end
			cl = 0; cr = 0; k = 0; on = 0; start = 0;
			foreach (evs[i]) begin
				if (evs[i].side == 0) cl += evs[i].kind ? -1 : 1;
				else cr += evs[i].kind ? -1 : 1;
				if (op == isa_pkg::OP_AND) f = cl > 0 && cr > 0;
				else if (op == isa_pkg::OP_OR) f = cl > 0 || cr > 0;
				else f = cl > 0 && cr <= 0;
				if (!on && f) begin
					start = evs[i].pos;
					on = 1;
				end else if (on && !f) begin
					on = 0;
					if (k < isa_pkg::MaxResults) begin
						it = '0;
						it.lo = start;
						it.hi = evs[i].pos;
						it.comp = comp;
						pending.insert(pending.size(), it);
						k++;
					end
				end
			end
			if (k == 0) begin
				it = '0;
				it.comp = comp;
				it.empty = 1;
				pending.insert(pending.size(), it);
			end
			pending[$].last = 1;
		endfunction

		// Note an accepted input transfer and queue what it should produce.
		function automatic void note_input(logic [2:0] fn, logic signed [31:0] lo,
				logic signed [31:0] hi);
			res_item_t it;
			bit        hit;
			it = '0;
			it.last = 1;
			case (fn)
				isa_pkg::FUNC_LOAD_A, isa_pkg::FUNC_LOAD_B: begin
					it.status = isa_pkg::ST_OK;
					if (fn == isa_pkg::FUNC_LOAD_A) begin
						foreach (a_list[i]) if (a_list[i].lo == lo && a_list[i].hi == hi)
							it.status = isa_pkg::ST_DUP;
						if (it.status == isa_pkg::ST_OK) begin
							if (a_list.size() >= isa_pkg::MaxIntervals)
								it.status = isa_pkg::ST_FULL;
							else a_list.insert(a_list.size(), span_t'{lo, hi});
						end
					end else begin
						foreach (b_list[i]) if (b_list[i].lo == lo && b_list[i].hi == hi)
							it.status = isa_pkg::ST_DUP;
						if (it.status == isa_pkg::ST_OK) begin
							if (b_list.size() >= isa_pkg::MaxIntervals)
								it.status = isa_pkg::ST_FULL;
							else b_list.insert(b_list.size(), span_t'{lo, hi});
						end
					end
					pending.insert(pending.size(), it);
				end
				isa_pkg::FUNC_ISECT: begin
					if (!comp_a && !comp_b) sweep(isa_pkg::OP_AND, 1, 0);
					else if (comp_a && comp_b) sweep(isa_pkg::OP_OR, 1, 1);
					else if (comp_a) sweep(isa_pkg::OP_DIFF, 0, 0);
					else sweep(isa_pkg::OP_DIFF, 1, 0);
				end
				isa_pkg::FUNC_UNITE: begin
					if (!comp_a && !comp_b) sweep(isa_pkg::OP_OR, 1, 0);
					else if (comp_a && comp_b) sweep(isa_pkg::OP_AND, 1, 1);
					else if (comp_a) sweep(isa_pkg::OP_DIFF, 1, 1);
					else sweep(isa_pkg::OP_DIFF, 0, 1);
				end
				isa_pkg::FUNC_CLEAR: begin
					a_list.delete();
					b_list.delete();
					pending.insert(pending.size(), it);
				end
				isa_pkg::FUNC_QUERY: begin
					hit = 0;
					foreach (a_list[i]) if (a_list[i].lo <= lo && lo <= a_list[i].hi) hit = 1;
					it.member = hit ^ comp_a;
					pending.insert(pending.size(), it);
				end
				default: ;  // unknown codes produce nothing
			endcase
		endfunction

		// Compare one accepted output transfer with the oldest expectation.
		function automatic void check_result(res_item_t got);
			res_item_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $realtime, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (want.empty != got.empty || want.comp != got.comp ||
					want.member != got.member || want.status != got.status ||
					want.last != got.last ||
					(!want.empty && (want.lo != got.lo || want.hi != got.hi)) ||
					(want.empty && (got.lo != 0 || got.hi != 0))) begin
				$display("%0t: mismatch, expected %h, actual %h", $realtime, want, got);
				errors++;
			end
		endfunction
	endclass

	localparam int IdleLimit = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic        cfg_index;
	logic        cfg_data;

	set_algebra_scoreboard board;
	int idle_cycles;

	interval_set_algebra_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Receiver: stalls come from a rotating pattern, reshuffled now and then.
	// Each accepted result transfer goes to the scoreboard.
	initial begin
		logic [15:0] stall_pat;
		int          ph;
		res_item_t   got;
		m_axis_tready = 0;
		stall_pat = 16'h0000;
		ph = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.lo = m_axis_tdata[31:0];
				got.hi = m_axis_tdata[63:32];
				got.comp = m_axis_tdata[64];
				got.empty = m_axis_tdata[65];
				got.member = m_axis_tdata[66];
				got.status = m_axis_tdata[68:67];
				got.last = m_axis_tlast;
				board.check_result(got);
			end
			ph = (ph + 1) % 16;
			if (ph == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pat = 16'h0000;
					1: stall_pat = 16'($urandom);
					2: stall_pat = 16'h8001;
					default: stall_pat = 16'hff00;
				endcase
			end
			m_axis_tready <= !stall_pat[ph];
		end
	end

	// Watchdog on cycles with no transfer on either stream.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	int burst_left;

	// Send one item; bursts of random length with random gaps between them.
	// Valid stays up after a transfer; drain, or the next call at the end of a burst, lowers it.
	task automatic send_item(logic [2:0] fn, logic signed [31:0] lo, logic signed [31:0] hi);
		if (burst_left == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 10);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {5'd0, hi, lo, fn};
		do @(posedge clk); while (!s_axis_tready);
		board.note_input(fn, lo, hi);
		burst_left--;
	endtask

	// Pause until every expected result has arrived, then let the block settle.
	task automatic drain();
		s_axis_tvalid <= 0;
		burst_left = 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// Write a complement flag; only done while the block is idle.
	task automatic write_flag(logic idx, logic val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == isa_pkg::CFG_COMP_A) board.comp_a = val;
		else board.comp_b = val;
	endtask

	function automatic logic signed [31:0] rand_point(int mode);
		case (mode)
			0: return $signed($urandom_range(0, 60)) - 30;
			1: return $urandom;
			default: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
		endcase
	endfunction

	initial begin
		logic signed [31:0] lo, hi;
		int                 r, mode, n;
		board = new();
		burst_left = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_flag(isa_pkg::CFG_COMP_A, 0);
		write_flag(isa_pkg::CFG_COMP_B, 0);

		// Directed part: empty stores, extremes, duplicate, reversed span, each operation.
		send_item(isa_pkg::FUNC_ISECT, 0, 0);
		send_item(isa_pkg::FUNC_UNITE, 0, 0);
		send_item(isa_pkg::FUNC_QUERY, 5, 0);
		send_item(isa_pkg::FUNC_LOAD_A, 32'sh80000000, 32'sh7fffffff);
		send_item(isa_pkg::FUNC_LOAD_A, 32'sh80000000, 32'sh7fffffff);
		send_item(isa_pkg::FUNC_LOAD_A, 10, -10);
		send_item(isa_pkg::FUNC_LOAD_B, -5, 5);
		send_item(isa_pkg::FUNC_LOAD_B, 5, 20);
		send_item(isa_pkg::FUNC_LOAD_B, 32'sh7fffffff, 32'sh7fffffff);
		send_item(isa_pkg::FUNC_ISECT, 0, 0);
		send_item(isa_pkg::FUNC_UNITE, 0, 0);
		send_item(isa_pkg::FUNC_QUERY, 32'sh80000000, 0);
		send_item(isa_pkg::FUNC_QUERY, 32'sh7fffffff, -1);
		send_item(3'd6, 1, 2);
		send_item(3'd7, -1, -2);
		send_item(isa_pkg::FUNC_CLEAR, 0, 0);
		for (int i = 0; i < 17; i++) send_item(isa_pkg::FUNC_LOAD_A, 2 * i, 2 * i + 1);
		drain();

		// Random part: phases under all four flag settings.
		for (int p = 0; p < 8; p++) begin
			write_flag(isa_pkg::CFG_COMP_A, p[0]);
			write_flag(isa_pkg::CFG_COMP_B, p[1]);
			send_item(isa_pkg::FUNC_CLEAR, $urandom, $urandom);
			n = 24;
			for (int i = 0; i < n; i++) begin
				r = $urandom_range(0, 99);
				mode = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
				lo = rand_point(mode);
				hi = ($urandom_range(0, 9) == 0) ? lo - 3 : lo + $urandom_range(0, 12);
				if (mode != 0) hi = rand_point(mode);
				if (r < 35) send_item(isa_pkg::FUNC_LOAD_A, lo, hi);
				else if (r < 70) send_item(isa_pkg::FUNC_LOAD_B, lo, hi);
				else if (r < 80) send_item(isa_pkg::FUNC_ISECT, lo, hi);
				else if (r < 90) send_item(isa_pkg::FUNC_UNITE, lo, hi);
				else if (r < 97) send_item(isa_pkg::FUNC_QUERY, lo, hi);
				else if (r < 98) send_item(isa_pkg::FUNC_CLEAR, lo, hi);
				else send_item(3'(6 + $urandom_range(0, 1)), lo, hi);
			end
			send_item(isa_pkg::FUNC_ISECT, $urandom, $urandom);
			send_item(isa_pkg::FUNC_UNITE, $urandom, $urandom);
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

FILE: sim.f
rtl/core/isa_pkg.sv
rtl/core/isa_sort_cell.sv
rtl/core/isa_store.sv
rtl/core/interval_set_algebra_unit.sv
sim/interval_set_algebra_unit_test.sv
